[rtl/lss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants of the 3x3 linear system solver
// Widths, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package lss_pkg;

	localparam int COEF_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int DET_OUT_W      = 49;
	localparam int SOL_W          = 64;
	localparam int ACC_W          = 72;
	localparam int DIV_W          = 128;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COF,
		ST_DET,
		ST_NUM,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       start_cof;
		logic       step;
		logic [3:0] idx;
		logic       clr_acc;
		logic       start_div;
		logic [1:0] comp;
		logic       load_out;
	} lss_cmd_t;

	typedef struct packed {
		logic det_zero;
		logic div_done;
	} lss_sts_t;

	localparam logic [1:0] ROW_LAST = 2'd2;
	localparam logic [1:0] ROW_NONE = 2'd3;

endpackage

[rtl/lss_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_in_if / lss_out_if: valid-ready channels of the solver
// Input carries one equation row, output one solved unknown.
// ----------------------------------------------------------------------------
interface lss_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         row;
	logic signed [15:0] coef_a;
	logic signed [15:0] coef_b;
	logic signed [15:0] coef_c;
	logic signed [15:0] rhs;
	modport source (output valid, row, coef_a, coef_b, coef_c, rhs, input ready);
	modport sink (input valid, row, coef_a, coef_b, coef_c, rhs, output ready);
endinterface

interface lss_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         component;
	logic signed [63:0] solution;
	logic signed [48:0] determinant;
	logic               singular;
	logic               saturated;
	logic               last;
	modport source (output valid, component, solution, determinant, singular,
		saturated, last, input ready);
	modport sink (input valid, component, solution, determinant, singular,
		saturated, last, output ready);
endinterface

[rtl/linear_system_solver_3x3.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_system_solver_3x3: solves A x = d by adjugate and fixed-point divide
// Rows 0..2 are stored; row 2 starts a solve that emits three results.
// ----------------------------------------------------------------------------
// Sequence: a row 0/1 item is written into the row store. Row 2 starts the solve:
// cofactor steps, determinant steps, then per unknown the numerator steps, the
// 128-step bit-serial division with start and done, and a load into the output.
// No new row is taken while a solve runs; the unknowns use the shared divider in
// turn, an unread result holds back the next load, a singular solve skips the division wait.
// Reset: arst_n clears the row store to zero and idles the sequencer.
module linear_system_solver_3x3
	import lss_pkg::*;
#(
	parameter int COEF_WIDTH = COEF_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input logic   clk,
	input logic   arst_n,
	lss_in_if.sink    in_ch,
	lss_out_if.source out_ch
);
	lss_cmd_t cmd;
	lss_sts_t sts;
	logic     wr;

	// Sequencer: accepts rows while idle, steps the datapath through a solve.
	lss_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_row(in_ch.row), .in_ready(in_ch.ready),
		.wr(wr), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd(cmd), .sts(sts)
	);

	// Datapath: row store, multipliers, divider and result register.
	lss_dp #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.wr(wr), .wr_row(in_ch.row),
		.wa(in_ch.coef_a), .wb(in_ch.coef_b), .wc(in_ch.coef_c), .wd(in_ch.rhs),
		.cmd(cmd), .sts(sts),
		.o_comp(out_ch.component), .o_sol(out_ch.solution),
		.o_det(out_ch.determinant), .o_sing(out_ch.singular),
		.o_sat(out_ch.saturated), .o_last(out_ch.last)
	);

	// A singular result always carries a zero solution.
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.singular |-> out_ch.solution == '0 && !out_ch.saturated)
		else $error("singular result with nonzero solution");

	// No row is taken while results are still pending, but for the last result.
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready || out_ch.last)
		else $error("row accepted during a solve");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(out_ch.solution))
		else $error("stalled result changed");
endmodule

[rtl/lss_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_div: restoring divider, one quotient bit per cycle while busy
// Magnitude division of a 128-bit dividend by a 64-bit divisor.
// ----------------------------------------------------------------------------
module lss_div
	import lss_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [DIV_W-1:0]       dividend,
	input  logic [63:0]            divisor,
	output logic                   done,
	output logic [DIV_W-1:0]       quotient
);
	logic [DIV_W-1:0] q_q;
	logic [64:0]      r_q;
	logic [63:0]      d_q;
	logic [7:0]       cnt_q;
	logic             busy_q;
	logic [64:0]      r_sh;
	logic             ge;

	assign r_sh = {r_q[63:0], q_q[DIV_W-1]};
	assign ge   = r_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 8'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - 8'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			r_q <= ge ? r_sh - {1'b0, d_q} : r_sh;
			q_q <= {q_q[DIV_W-2:0], ge};
		end
	end

	assign quotient = q_q;
endmodule

[rtl/lss_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_dp: solver datapath
// Row store, cofactor and product multipliers, accumulator, divider and output register.
// ----------------------------------------------------------------------------
module lss_dp
	import lss_pkg::*;
#(
	parameter int COEF_WIDTH = COEF_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [1:0]   wr_row,
	input  logic [15:0]  wa,
	input  logic [15:0]  wb,
	input  logic [15:0]  wc,
	input  logic [15:0]  wd,
	input  lss_cmd_t     cmd,
	output lss_sts_t     sts,
	output logic [1:0]   o_comp,
	output logic [63:0]  o_sol,
	output logic [48:0]  o_det,
	output logic         o_sing,
	output logic         o_sat,
	output logic         o_last
);
	localparam int CW = COEF_WIDTH;
	localparam int PW = 2 * CW + 2;   // cofactor width
	localparam int MW = 3 * CW + 4;   // det / numerator width

	logic signed [CW-1:0] a_q [9];
	logic signed [CW-1:0] d_q [3];
	logic signed [PW-1:0] adj_q [9];
	logic signed [MW-1:0] det_q;
	logic signed [MW-1:0] acc_q;

	// cofactor pairs: adj[k] = a[p0]*a[p1] - a[p2]*a[p3], sign folded into the pair order
	function automatic logic [15:0] cof_sel(input logic [3:0] k);
		case (k)
			4'd0: cof_sel = {4'd4, 4'd8, 4'd5, 4'd7};
			4'd1: cof_sel = {4'd2, 4'd7, 4'd1, 4'd8};
			4'd2: cof_sel = {4'd1, 4'd5, 4'd2, 4'd4};
			4'd3: cof_sel = {4'd5, 4'd6, 4'd3, 4'd8};
			4'd4: cof_sel = {4'd0, 4'd8, 4'd2, 4'd6};
			4'd5: cof_sel = {4'd2, 4'd3, 4'd0, 4'd5};
			4'd6: cof_sel = {4'd3, 4'd7, 4'd4, 4'd6};
			4'd7: cof_sel = {4'd1, 4'd6, 4'd0, 4'd7};
			4'd8: cof_sel = {4'd0, 4'd4, 4'd1, 4'd3};
			default: cof_sel = '0;
		endcase
	endfunction

	logic [15:0]          sel;
	logic signed [2*CW-1:0] p0, p1;
	logic signed [PW-1:0] cof;
	logic signed [MW-1:0] prod;
	logic [1:0]           k3;
	logic [3:0]           ai;

	always_comb begin
		sel = cof_sel(cmd.idx);
		p0  = a_q[sel[15:12]] * a_q[sel[11:8]];
		p1  = a_q[sel[7:4]] * a_q[sel[3:0]];
		cof = PW'(p0) - PW'(p1);
		k3  = cmd.idx[1:0];
		ai  = 4'(cmd.comp) * 4'd3 + {2'b0, k3};
		// det step uses a[k]*adj[3k]; numerator step uses adj[3c+k]*d[k]
		if (cmd.start_cof)
			prod = MW'(a_q[4'(k3)]) * MW'(adj_q[4'(k3) * 4'd3]);
		else
			prod = MW'(adj_q[ai]) * MW'(d_q[k3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) a_q[i] <= '0;
			for (int i = 0; i < 3; i++) d_q[i] <= '0;
		end else if (wr) begin
			a_q[4'(wr_row) * 4'd3]        <= CW'(wa);
			a_q[4'(wr_row) * 4'd3 + 4'd1] <= CW'(wb);
			a_q[4'(wr_row) * 4'd3 + 4'd2] <= CW'(wc);
			d_q[wr_row]                    <= CW'(wd);
		end
	end

	// divider feed: the numerator is final in acc_q when the division starts
	logic                   neg_q;
	logic [63:0]            nm, dm;
	logic [DIV_W-1:0]       dvd;
	logic                   div_done;
	logic [DIV_W-1:0]       quo;
	logic signed [63:0]     num64, det64;

	assign num64 = 64'(acc_q);
	assign det64 = 64'(det_q);
	assign nm  = num64[63] ? 64'(-num64) : num64;
	assign dm  = det64[63] ? 64'(-det64) : det64;
	assign dvd = DIV_W'(nm) << FRAC_BITS;

	lss_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.start_div),
		.dividend(dvd), .divisor(dm), .done(div_done), .quotient(quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.step && !cmd.start_cof && cmd.idx[3:2] == 2'b00 && cmd.clr_acc)
			det_q <= det_q;
		if (cmd.step && cmd.clr_acc) begin
			// cofactor pass: idx runs 0..8
			adj_q[cmd.idx] <= cof;
		end
		if (cmd.step && cmd.start_cof) begin
			if (k3 == 2'd0) det_q <= prod;
			else det_q <= det_q + prod;
		end
		if (cmd.step && !cmd.start_cof && !cmd.clr_acc) begin
			if (k3 == 2'd0) acc_q <= prod;
			else acc_q <= acc_q + prod;
		end
		if (cmd.start_div) begin
			neg_q <= acc_q[MW-1] ^ det_q[MW-1];
		end
		if (cmd.load_out) begin
			o_comp <= cmd.comp;
			o_det  <= 49'(det_q);
			o_sing <= det_q == '0;
			o_last <= cmd.comp == 2'd2;
			if (det_q == '0) begin
				o_sol <= '0;
				o_sat <= 1'b0;
			end else if (!neg_q) begin
				o_sat <= quo[DIV_W-1:63] != '0;
				o_sol <= quo[DIV_W-1:63] != '0 ? 64'h7fff_ffff_ffff_ffff : quo[63:0];
			end else begin
				o_sat <= quo[DIV_W-1:64] != '0 || quo[63:0] > 64'h8000_0000_0000_0000;
				o_sol <= (quo[DIV_W-1:64] != '0 ||
					quo[63:0] > 64'h8000_0000_0000_0000) ?
					64'h8000_0000_0000_0000 : 64'(-quo[63:0]);
			end
		end
	end

	assign sts.det_zero = det_q == '0;
	assign sts.div_done = div_done;
endmodule

[rtl/lss_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_ctrl: solver sequencer
// Steps cofactors, determinant, numerators and divisions; hands out results.
// ----------------------------------------------------------------------------
module lss_ctrl
	import lss_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic [1:0] in_row,
	output logic     in_ready,
	output logic     wr,
	output logic     out_valid,
	input  logic     out_ready,
	output lss_cmd_t cmd,
	input  lss_sts_t sts
);
	state_t     st_q, st_d;
	logic [3:0] idx_q, idx_d;
	logic [1:0] comp_q, comp_d;
	logic       ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; idx_q <= '0; comp_q <= '0; ov_q <= 1'b0;
		end else begin
			st_q <= st_d; idx_q <= idx_d; comp_q <= comp_d; ov_q <= ov_d;
		end
	end

	always_comb begin
		st_d = st_q; idx_d = idx_q; comp_d = comp_q; ov_d = ov_q;
		cmd = '0;
		cmd.idx  = idx_q;
		cmd.comp = comp_q;
		in_ready = 1'b0;
		wr = 1'b0;
		if (ov_q && out_ready) ov_d = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_row != ROW_NONE) begin
					wr = 1'b1;
					if (in_row == ROW_LAST) begin
						st_d = ST_COF; idx_d = '0;
					end
				end
			end
			ST_COF: begin
				cmd.step = 1'b1; cmd.clr_acc = 1'b1;
				idx_d = idx_q + 4'd1;
				if (idx_q == 4'd8) begin
					st_d = ST_DET; idx_d = '0;
				end
			end
			ST_DET: begin
				cmd.step = 1'b1; cmd.start_cof = 1'b1;
				idx_d = idx_q + 4'd1;
				if (idx_q == 4'd2) begin
					st_d = ST_NUM; idx_d = '0; comp_d = '0;
				end
			end
			ST_NUM: begin
				cmd.step = 1'b1;
				idx_d = idx_q + 4'd1;
				if (idx_q == 4'd2) begin
					st_d = ST_DIV; idx_d = '0;
				end
			end
			ST_DIV: begin
				// done is a one-cycle pulse: take it at once, ST_OUT waits for room
				if (idx_q == '0) begin
					cmd.start_div = 1'b1; idx_d = 4'd1;
				end else if (sts.div_done || sts.det_zero) begin
					st_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!ov_q || out_ready) begin
					cmd.load_out = 1'b1; ov_d = 1'b1; idx_d = '0;
					if (comp_q == 2'd2) st_d = ST_IDLE;
					else begin
						comp_d = comp_q + 2'd1; st_d = ST_NUM;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	assign out_valid = ov_q;
endmodule
